// ----- sv/ptq_pkg.sv -----
`default_nettype none

package ptq_pkg;

   localparam int TIMER_COUNT  = 16;
   localparam int TIME_WIDTH   = 48;
   localparam int ID_WIDTH     = 4;
   localparam int PERIOD_WIDTH = 32;
   localparam int MODE_WIDTH   = 2;
   localparam int SLOT_WIDTH   = $clog2(TIMER_COUNT);
   localparam int CNT_WIDTH    = $clog2(TIMER_COUNT + 1);
   localparam int SUM_WIDTH    =
      ((TIME_WIDTH > PERIOD_WIDTH) ? TIME_WIDTH : PERIOD_WIDTH) + 1;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_TICK    = 2'd0,
      MODE_ENABLE  = 2'd1,
      MODE_DISABLE = 2'd2,
      MODE_RESTART = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_REMOVE,
      ST_INSERT,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic capture;
      logic decide;
      logic fire;
      logic ignore;
      logic write_period;
      logic set_active;
      logic clear_active;
      logic remove;
      logic remove_head;
      logic insert;
      logic respond;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     id_ok;
      logic     active;
      logic     due;
      logic     out_busy;
   } status_type;

   function automatic logic [TIME_WIDTH-1:0] sat_add(
      input logic [TIME_WIDTH-1:0]   base,
      input logic [PERIOD_WIDTH-1:0] per
   );
      logic [SUM_WIDTH-1:0] sum;
      sum = SUM_WIDTH'(base) + SUM_WIDTH'(per);
      if (sum[SUM_WIDTH-1:TIME_WIDTH] != '0) begin
         return {TIME_WIDTH{1'b1}};
      end
      return sum[TIME_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- sv/ptq_ctrl.sv -----
`default_nettype none

module ptq_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire ptq_pkg::status_type status,
   output ptq_pkg::cmd_type        cmd
);

   typedef struct packed {
      logic remove;
      logic insert;
      logic head;
   } plan_type;

   ptq_pkg::state_type state_ff, state_in;
   plan_type           plan_ff, plan_in;
   logic               fire, ignore;

   always_comb begin
      fire   = (status.mode == ptq_pkg::MODE_TICK) && status.due;
      ignore = 1'b0;
      unique case (status.mode)
         ptq_pkg::MODE_TICK:    ignore = 1'b0;
         ptq_pkg::MODE_ENABLE:  ignore = !status.id_ok || status.active;
         ptq_pkg::MODE_DISABLE,
         ptq_pkg::MODE_RESTART: ignore = !status.id_ok || !status.active;
         default:               ignore = 1'b1;
      endcase
      plan_in.head   = fire;
      plan_in.remove = fire || (!ignore && ((status.mode == ptq_pkg::MODE_DISABLE) ||
                                            (status.mode == ptq_pkg::MODE_RESTART)));
      plan_in.insert = fire || (!ignore && ((status.mode == ptq_pkg::MODE_ENABLE) ||
                                            (status.mode == ptq_pkg::MODE_RESTART)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ptq_pkg::ST_DECIDE) begin
         plan_ff <= plan_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptq_pkg::ST_IDLE: begin
            if (req_valid) state_in = ptq_pkg::ST_DECIDE;
         end
         ptq_pkg::ST_DECIDE: begin
            if (plan_in.remove) state_in = ptq_pkg::ST_REMOVE;
            else if (plan_in.insert) state_in = ptq_pkg::ST_INSERT;
            else state_in = ptq_pkg::ST_RESPOND;
         end
         ptq_pkg::ST_REMOVE: begin
            state_in = plan_ff.insert ? ptq_pkg::ST_INSERT : ptq_pkg::ST_RESPOND;
         end
         ptq_pkg::ST_INSERT: begin
            state_in = ptq_pkg::ST_RESPOND;
         end
         ptq_pkg::ST_RESPOND: begin
            if (!status.out_busy) state_in = ptq_pkg::ST_IDLE;
         end
         default: state_in = ptq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ptq_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ptq_pkg::ST_DECIDE: begin
            cmd.decide       = 1'b1;
            cmd.fire         = fire;
            cmd.ignore       = ignore;
            cmd.write_period = !ignore && (status.mode == ptq_pkg::MODE_ENABLE);
            cmd.set_active   = !ignore && (status.mode == ptq_pkg::MODE_ENABLE);
            cmd.clear_active = !ignore && (status.mode == ptq_pkg::MODE_DISABLE);
         end
         ptq_pkg::ST_REMOVE: begin
            cmd.remove      = 1'b1;
            cmd.remove_head = plan_ff.head;
         end
         ptq_pkg::ST_INSERT: begin
            cmd.insert = 1'b1;
         end
         ptq_pkg::ST_RESPOND: begin
            cmd.respond = !status.out_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- sv/ptq_datapath.sv -----
`default_nettype none

module ptq_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire ptq_pkg::cmd_type                  cmd,
   output ptq_pkg::status_type                    status,
   input  wire logic [ptq_pkg::MODE_WIDTH-1:0]    req_mode,
   input  wire logic [ptq_pkg::ID_WIDTH-1:0]      req_timer_id,
   input  wire logic [ptq_pkg::PERIOD_WIDTH-1:0]  req_period,
   input  wire logic [ptq_pkg::TIME_WIDTH-1:0]    req_now,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_fired,
   output logic [ptq_pkg::ID_WIDTH-1:0]           rsp_fired_id,
   output logic                                   rsp_status,
   output logic                                   rsp_head_valid,
   output logic [ptq_pkg::TIME_WIDTH-1:0]         rsp_head_deadline
);

   localparam int N  = ptq_pkg::TIMER_COUNT;
   localparam int SW = ptq_pkg::SLOT_WIDTH;
   localparam int CW = ptq_pkg::CNT_WIDTH;
   localparam int TW = ptq_pkg::TIME_WIDTH;
   localparam int PW = ptq_pkg::PERIOD_WIDTH;

   logic [PW-1:0]       period_mem [N];
   logic [PW-1:0]       per_rd_ff;
   logic [N-1:0]        active_ff;

   logic [SW-1:0]       slot_id_ff [N];
   logic [SW-1:0]       slot_id_in [N];
   logic [TW-1:0]       slot_dl_ff [N];
   logic [TW-1:0]       slot_dl_in [N];
   logic [CW-1:0]       count_ff, count_in;

   ptq_pkg::mode_type   mode_ff;
   logic [SW-1:0]       id_ff;
   logic                id_ok_ff;
   logic [PW-1:0]       per_in_ff;
   logic [TW-1:0]       now_ff;

   logic [SW-1:0]       ins_id_ff;
   logic [TW-1:0]       ins_dl_ff;
   logic                fired_ff;
   logic                ignored_ff;

   logic                rsp_valid_ff;
   logic                rsp_fired_ff;
   logic [ptq_pkg::ID_WIDTH-1:0] rsp_fired_id_ff;
   logic                rsp_status_ff;
   logic                rsp_head_valid_ff;
   logic [TW-1:0]       rsp_head_deadline_ff;

   logic [SW-1:0]       rd_addr;
   logic [TW-1:0]       base;
   logic [PW-1:0]       per_sel;
   logic [N-1:0]        match;
   logic [N-1:0]        lt;
   logic                hit;
   logic                lt_prev;
   logic [SW-1:0]       prev_id;
   logic [TW-1:0]       prev_dl;

   assign rd_addr = (ptq_pkg::mode_type'(req_mode) == ptq_pkg::MODE_TICK) ?
                    slot_id_ff[0] : SW'(req_timer_id);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         per_rd_ff <= period_mem[rd_addr];
         mode_ff   <= ptq_pkg::mode_type'(req_mode);
         id_ff     <= SW'(req_timer_id);
         id_ok_ff  <= (32'(req_timer_id) < N);
         per_in_ff <= req_period;
         now_ff    <= req_now;
      end
      if (cmd.write_period) begin
         period_mem[id_ff] <= per_in_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (cmd.set_active) begin
         active_ff[id_ff] <= 1'b1;
      end else if (cmd.clear_active) begin
         active_ff[id_ff] <= 1'b0;
      end
   end

   assign status.mode     = mode_ff;
   assign status.id_ok    = id_ok_ff;
   assign status.active   = active_ff[id_ff];
   assign status.due      = (count_ff != '0) && (now_ff >= slot_dl_ff[0]);
   assign status.out_busy = rsp_valid_ff && rsp_stall;

   assign base    = (mode_ff == ptq_pkg::MODE_TICK) ? slot_dl_ff[0] : now_ff;
   assign per_sel = (mode_ff == ptq_pkg::MODE_ENABLE) ? per_in_ff : per_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         ins_dl_ff  <= ptq_pkg::sat_add(base, per_sel);
         ins_id_ff  <= (mode_ff == ptq_pkg::MODE_TICK) ? slot_id_ff[0] : id_ff;
         fired_ff   <= cmd.fire;
         ignored_ff <= cmd.ignore;
      end
   end

   always_comb begin
      for (int k = 0; k < N; k++) begin
         match[k] = (CW'(k) < count_ff) &&
                    (cmd.remove_head ? (k == 0) : (slot_id_ff[k] == id_ff));
         lt[k]    = (CW'(k) < count_ff) && (slot_dl_ff[k] < ins_dl_ff);
      end
   end

   always_comb begin
      slot_id_in = slot_id_ff;
      slot_dl_in = slot_dl_ff;
      count_in   = count_ff;
      hit        = 1'b0;
      lt_prev    = 1'b1;
      prev_id    = ins_id_ff;
      prev_dl    = ins_dl_ff;
      if (cmd.remove && (match != '0)) begin
         for (int k = 0; k < N - 1; k++) begin
            hit = hit || match[k];
            if (hit) begin
               slot_id_in[k] = slot_id_ff[k + 1];
               slot_dl_in[k] = slot_dl_ff[k + 1];
            end
         end
         count_in = count_ff - CW'(1);
      end else if (cmd.insert && (count_ff < CW'(N))) begin
         for (int k = 0; k < N; k++) begin
            if ((CW'(k) <= count_ff) && !lt[k]) begin
               if (lt_prev) begin
                  slot_id_in[k] = ins_id_ff;
                  slot_dl_in[k] = ins_dl_ff;
               end else begin
                  slot_id_in[k] = prev_id;
                  slot_dl_in[k] = prev_dl;
               end
            end
            lt_prev = lt[k];
            prev_id = slot_id_ff[k];
            prev_dl = slot_dl_ff[k];
         end
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      slot_id_ff <= slot_id_in;
      slot_dl_ff <= slot_dl_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.respond) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_fired_ff         <= fired_ff;
         rsp_fired_id_ff      <= fired_ff ? ptq_pkg::ID_WIDTH'(ins_id_ff) : '0;
         rsp_status_ff        <= ignored_ff;
         rsp_head_valid_ff    <= (count_ff != '0);
         rsp_head_deadline_ff <= (count_ff != '0) ? slot_dl_ff[0] : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fired         = rsp_fired_ff;
   assign rsp_fired_id      = rsp_fired_id_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_head_valid    = rsp_head_valid_ff;
   assign rsp_head_deadline = rsp_head_deadline_ff;

endmodule

`default_nettype wire

// ----- sv/periodic_timer_queue_core.sv -----
// channel  direction  handshake             payload
// req      in         req_valid/req_stall   mode, timer_id, period, now
// rsp      out        rsp_valid/rsp_stall   fired, fired_id, status, head_valid, head_deadline
//
// An item runs through capture, decide, an optional list removal, an optional sorted
// insert, and the response load. The sorted list shifts all of its entries within one step.
// Reset clears the state, enable bits, list count and response valid; nothing else.
// A result waits in the response register; the next item is taken while it waits and
// holds in the response step until the register frees.
`default_nettype none

module periodic_timer_queue_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [ptq_pkg::MODE_WIDTH-1:0]    req_mode,
   input  wire logic [ptq_pkg::ID_WIDTH-1:0]      req_timer_id,
   input  wire logic [ptq_pkg::PERIOD_WIDTH-1:0]  req_period,
   input  wire logic [ptq_pkg::TIME_WIDTH-1:0]    req_now,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_fired,
   output logic [ptq_pkg::ID_WIDTH-1:0]           rsp_fired_id,
   output logic                                   rsp_status,
   output logic                                   rsp_head_valid,
   output logic [ptq_pkg::TIME_WIDTH-1:0]         rsp_head_deadline
);

   ptq_pkg::cmd_type    cmd;
   ptq_pkg::status_type status;

   ptq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ptq_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_mode          (req_mode),
      .req_timer_id      (req_timer_id),
      .req_period        (req_period),
      .req_now           (req_now),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_fired         (rsp_fired),
      .rsp_fired_id      (rsp_fired_id),
      .rsp_status        (rsp_status),
      .rsp_head_valid    (rsp_head_valid),
      .rsp_head_deadline (rsp_head_deadline)
   );

endmodule

`default_nettype wire

// ----- sv/ptq_checker.sv -----
`default_nettype none

module ptq_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_stall,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic                              rsp_fired,
   input wire logic [ptq_pkg::ID_WIDTH-1:0]      rsp_fired_id,
   input wire logic                              rsp_status,
   input wire logic                              rsp_head_valid,
   input wire logic [ptq_pkg::TIME_WIDTH-1:0]    rsp_head_deadline
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous item still in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_head_deadline) &&
                                 $stable(rsp_fired_id))
      else $error("stalled response changed");

   a_empty_deadline: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_head_valid |-> rsp_head_deadline == '0)
      else $error("empty queue reports a deadline");

   a_quiet_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fired |-> rsp_fired_id == '0)
      else $error("id reported without a firing");

   a_fire_keeps_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fired |-> rsp_head_valid && !rsp_status)
      else $error("fired timer missing from queue");

endmodule

bind periodic_timer_queue_core ptq_checker u_ptq_checker (.*);

`default_nettype wire
